@@ design/elmf_pkg.sv @@
// Shared constants, types and helpers for the electrode level mode filter.
// No dependencies; used by electrode_level_mode_filter.
package elmf_pkg;

    // Ring length (1..32) and the widths that follow from it
    localparam int WINDOW = 8;
    localparam int W_SLOT = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int W_CNT  = $clog2(WINDOW + 1);

    localparam int W_PCT     = 7;
    localparam int W_CODE    = 2;
    localparam int W_CONTACT = 2;
    localparam int W_CFG_IDX = 2;
    localparam int N_CODES   = 3;

    localparam logic [W_CNT-1:0]  CNT_FULL  = W_CNT'(WINDOW);
    localparam logic [W_SLOT-1:0] SLOT_LAST = W_SLOT'(WINDOW - 1);

    localparam logic [W_PCT-1:0] PCT_MAX = 7'd100;
    localparam logic [W_PCT-1:0] PCT_LO_RESET = 7'd50;
    localparam logic [W_PCT-1:0] PCT_HI_RESET = 7'd100;
    localparam logic [W_PCT-1:0] THRESH_RESET = 7'd5;

    // Level codes
    typedef enum logic [W_CODE-1:0] {
        CODE_NONE = 2'd0,
        CODE_LOW  = 2'd1,
        CODE_HIGH = 2'd2
    } t_code;

    // Register indexes on the config port
    typedef enum logic [W_CFG_IDX-1:0] {
        REG_PCT_LOW  = 2'd0,
        REG_PCT_HIGH = 2'd1,
        REG_THRESH   = 2'd2
    } t_reg_idx;

    // Highest contacted electrode plus one
    function automatic t_code contact_to_code(input logic [W_CONTACT-1:0] contact);
        t_code code;
        if (contact[1]) begin
            code = CODE_HIGH;
        end else if (contact[0]) begin
            code = CODE_LOW;
        end else begin
            code = CODE_NONE;
        end
        return code;
    endfunction

    // Code to percent, clamped to 100
    function automatic logic [W_PCT-1:0] code_to_pct(
        input t_code            code,
        input logic [W_PCT-1:0] pct_low,
        input logic [W_PCT-1:0] pct_high
    );
        logic [W_PCT-1:0] p;
        case (code)
            CODE_LOW:  p = pct_low;
            CODE_HIGH: p = pct_high;
            default:   p = '0;
        endcase
        return (p > PCT_MAX) ? PCT_MAX : p;
    endfunction

endpackage

@@ design/electrode_level_mode_filter.sv @@
// Electrode level mode filter: ring of level codes, running mode, deadband publish.
// Depends on elmf_pkg (constants, code types, mapping functions).
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+------------------------------------------
//  in      | i_in_valid   | o_in_ready   | i_electrode_contact, i_force_req
//  out     | o_out_valid  | i_out_ready  | o_publish, o_level_percent
//  cfg     | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One word per clock sustained while i_out_ready holds; an input register, then a result
// register. The per-code counters, updated on insert and evict, give the mode
// combinationally in the compute stage between those registers.
// Reset (synchronous, active low) empties the pipeline, clears ring position, fill
// count and publish history, and loads the config registers with their defaults.
// A held result stalls the compute stage, which backs up into o_in_ready.
// The config port is always ready.
module electrode_level_mode_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input words
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [elmf_pkg::W_CONTACT-1:0] i_electrode_contact,
    input  logic                          i_force_req,
    // result words
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_publish,
    output logic [elmf_pkg::W_PCT-1:0]    o_level_percent,
    // config writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [elmf_pkg::W_CFG_IDX-1:0] i_cfg_index,
    input  logic [elmf_pkg::W_PCT-1:0]    i_cfg_data
);

    // ---------------- config registers ----------------
    logic [elmf_pkg::W_PCT-1:0] r_pct_low, r_pct_high, r_thresh;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct_low  <= elmf_pkg::PCT_LO_RESET;
            r_pct_high <= elmf_pkg::PCT_HI_RESET;
            r_thresh   <= elmf_pkg::THRESH_RESET;
        end else if (i_cfg_valid) begin
            unique case (elmf_pkg::t_reg_idx'(i_cfg_index))
                elmf_pkg::REG_PCT_LOW:  r_pct_low  <= i_cfg_data;
                elmf_pkg::REG_PCT_HIGH: r_pct_high <= i_cfg_data;
                elmf_pkg::REG_THRESH:   r_thresh   <= i_cfg_data;
                default: ;  // unknown index: dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                           r_in_vld;
    logic [elmf_pkg::W_CONTACT-1:0] r_contact;
    logic                           r_force;
    logic                           r_out_vld;
    logic                           advance;   // result register can load
    logic                           fire;      // compute stage processes a word

    assign advance    = !r_out_vld || i_out_ready;
    assign fire       = r_in_vld && advance;
    assign o_in_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_contact <= i_electrode_contact;
            r_force   <= i_force_req;
        end
    end

    // ---------------- filter state ----------------
    // ring contents need no reset: entries are read only once all are written
    logic [elmf_pkg::W_CODE-1:0] r_ring [elmf_pkg::WINDOW];
    logic [elmf_pkg::W_SLOT-1:0] r_slot, n_slot;
    logic [elmf_pkg::W_CNT-1:0]  r_fill, n_fill;
    logic [elmf_pkg::W_CNT-1:0]  r_cnt [elmf_pkg::N_CODES];
    logic [elmf_pkg::W_CNT-1:0]  n_cnt [elmf_pkg::N_CODES];
    logic [elmf_pkg::W_PCT-1:0]  r_last, n_last;
    logic                        r_has_pub, n_has_pub;

    elmf_pkg::t_code             code_new, code_old, code_mode;
    logic                        full_now, full_next;
    logic [elmf_pkg::W_PCT-1:0]  pct_raw, pct_mode, pct_diff, pct_out;
    logic                        pub;

    always_comb begin
        code_new  = elmf_pkg::contact_to_code(r_contact);
        code_old  = elmf_pkg::t_code'(r_ring[r_slot]);
        full_now  = (r_fill == elmf_pkg::CNT_FULL);

        n_slot    = (r_slot == elmf_pkg::SLOT_LAST) ? '0 : r_slot + 1'b1;
        n_fill    = full_now ? r_fill : r_fill + 1'b1;
        full_next = (n_fill == elmf_pkg::CNT_FULL);

        // running counts: add the new code, drop the one it overwrites
        for (int c = 0; c < elmf_pkg::N_CODES; c++) begin
            n_cnt[c] = r_cnt[c]
                     + elmf_pkg::W_CNT'(code_new == elmf_pkg::t_code'(c))
                     - elmf_pkg::W_CNT'(full_now && code_old == elmf_pkg::t_code'(c));
        end

        // mode, ties go to the higher code
        code_mode = elmf_pkg::CODE_NONE;
        if (n_cnt[1] >= n_cnt[0]) begin
            code_mode = elmf_pkg::CODE_LOW;
        end
        if (n_cnt[2] >= n_cnt[code_mode]) begin
            code_mode = elmf_pkg::CODE_HIGH;
        end

        pct_raw  = elmf_pkg::code_to_pct(code_new, r_pct_low, r_pct_high);
        pct_mode = elmf_pkg::code_to_pct(code_mode, r_pct_low, r_pct_high);
        pct_diff = (pct_mode > r_last) ? pct_mode - r_last : r_last - pct_mode;

        if (r_force) begin
            pub     = 1'b1;
            pct_out = pct_raw;
        end else if (full_next && (!r_has_pub || pct_diff >= r_thresh)) begin
            pub     = 1'b1;
            pct_out = pct_mode;
        end else begin
            pub     = 1'b0;
            pct_out = '0;
        end

        n_last    = pub ? pct_out : r_last;
        n_has_pub = r_has_pub || pub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_fill    <= '0;
            r_last    <= '0;
            r_has_pub <= 1'b0;
            for (int c = 0; c < elmf_pkg::N_CODES; c++) begin
                r_cnt[c] <= '0;
            end
        end else if (fire) begin
            r_slot    <= n_slot;
            r_fill    <= n_fill;
            r_last    <= n_last;
            r_has_pub <= n_has_pub;
            for (int c = 0; c < elmf_pkg::N_CODES; c++) begin
                r_cnt[c] <= n_cnt[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ring[r_slot] <= code_new;
        end
    end

    // ---------------- result register ----------------
    logic                       r_publish;
    logic [elmf_pkg::W_PCT-1:0] r_pct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_publish <= pub;
            r_pct     <= pct_out;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_publish       = r_publish;
    assign o_level_percent = r_pct;

`ifndef SYNTHESIS
    // counters always account for exactly the codes held in the ring
    a_cnt_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (({2'b00, r_cnt[0]} + {2'b00, r_cnt[1]} + {2'b00, r_cnt[2]})
            == {2'b00, r_fill}))
        else $error("code counters disagree with fill count");

    // until the ring is full the write slot tracks the fill count
    a_slot_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != elmf_pkg::CNT_FULL) |-> (elmf_pkg::W_CNT'(r_slot) == r_fill))
        else $error("write slot out of step with fill count");

    // no history before the first publish
    a_no_hist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_has_pub |-> (r_last == '0))
        else $error("last published value set without a publish");

    // a processed word always lands in the result register
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_vld)
        else $error("processed word lost");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for electrode_level_mode_filter.
// Depends on elmf_pkg and the filter RTL. A scoreboard class predicts each result word
// from the accepted input words, and random stalls on both sides exercise the handshakes.
`timescale 1ns / 1ps

module testbench;
    import elmf_pkg::*;

    // Config index past the register list; the block must ignore writes to it
    localparam logic [W_CFG_IDX-1:0] REG_SPARE = 2'd3;
    // Output stall that backs the block up into its input
    localparam int HOLD_CYCLES = 200;
    localparam int PHASES      = 11;
    localparam int PHASE_WORDS = 130;
    localparam int N_DIRECTED  = 24;
    // Directed words, first word in the top nibble: bit 3 = force, bits 1:0 = contact.
    // Fills the ring with a force before it is full, hits the high-code tie, forces
    // on a full ring, then drifts to code 0 and back with more forces.
    localparam logic [4*N_DIRECTED-1:0] DIRECTED_SEQ = 96'h0392_1122_1810_0000_00B2_3A10;

    // One result word as the block should present it
    typedef struct packed {
        logic             publish;
        logic [W_PCT-1:0] pct;
    } t_publish_word;

    // Tracks the ring, the publish history and the config, and holds the result
    // words still owed by the block, oldest first.
    class t_publish_board;
        t_code            ring [WINDOW];
        int unsigned      slot;
        int unsigned      fill;
        logic [W_PCT-1:0] last_pct;
        bit               published;
        logic [W_PCT-1:0] pct_low;
        logic [W_PCT-1:0] pct_high;
        logic [W_PCT-1:0] threshold;
        t_publish_word    owed_words [$];
        int unsigned      mismatches;

        function new();
            foreach (ring[i]) ring[i] = CODE_NONE;
            slot       = 0;
            fill       = 0;
            last_pct   = '0;
            published  = 1'b0;
            pct_low    = PCT_LO_RESET;
            pct_high   = PCT_HI_RESET;
            threshold  = THRESH_RESET;
            mismatches = 0;
        endfunction

        task report(input string what);
            mismatches++;
            $display("mismatch @%0t: %s", $realtime, what);
        endtask

        function int pending();
            return owed_words.size();
        endfunction

        function void load_reg(input logic [W_CFG_IDX-1:0] idx,
                               input logic [W_PCT-1:0] data);
            case (idx)
                REG_PCT_LOW:  pct_low   = data;
                REG_PCT_HIGH: pct_high  = data;
                REG_THRESH:   threshold = data;
                default: ;  // spare index: dropped
            endcase
        endfunction

        function logic [W_PCT-1:0] level_pct(input t_code code);
            logic [W_PCT-1:0] p;
            if (code == CODE_LOW) begin
                p = pct_low;
            end else if (code == CODE_HIGH) begin
                p = pct_high;
            end else begin
                p = '0;
            end
            if (p > PCT_MAX) p = PCT_MAX;
            return p;
        endfunction

        // Most frequent code in the ring; ties go to the higher code
        function t_code ring_mode();
            int    tally [N_CODES];
            t_code best;
            foreach (tally[c]) tally[c] = 0;
            foreach (ring[i]) tally[ring[i]]++;
            best = CODE_NONE;
            if (tally[CODE_LOW] >= tally[best]) best = CODE_LOW;
            if (tally[CODE_HIGH] >= tally[best]) best = CODE_HIGH;
            return best;
        endfunction

        task note_sample(input logic [W_CONTACT-1:0] contact, input logic forced);
            t_code            code;
            logic [W_PCT-1:0] mode_pct;
            logic [W_PCT-1:0] delta;
            t_publish_word    word;
            if (contact[1]) begin
                code = CODE_HIGH;
            end else if (contact[0]) begin
                code = CODE_LOW;
            end else begin
                code = CODE_NONE;
            end
            ring[slot] = code;
            slot = (slot == WINDOW - 1) ? 0 : slot + 1;
            if (fill < WINDOW) fill++;

            word = '0;
            if (forced) begin
                // force: raw level right away, full ring or not
                word.publish = 1'b1;
                word.pct     = level_pct(code);
            end else if (fill == WINDOW) begin
                mode_pct = level_pct(ring_mode());
                delta = (mode_pct > last_pct) ? mode_pct - last_pct : last_pct - mode_pct;
                if (!published || delta >= threshold) begin
                    word.publish = 1'b1;
                    word.pct     = mode_pct;
                end
            end
            if (word.publish) begin
                last_pct  = word.pct;
                published = 1'b1;
            end
            owed_words.push_back(word);
        endtask

        task check_publish(input logic pub, input logic [W_PCT-1:0] pct);
            t_publish_word want;
            if (owed_words.size() == 0) begin
                report($sformatf("result word with none owed: publish=%0b pct=%0d", pub, pct));
                return;
            end
            want = owed_words.pop_front();
            if (pub !== want.publish)
                report($sformatf("publish %0b, want %0b", pub, want.publish));
            if (pct !== want.pct)
                report($sformatf("level_percent %0d, want %0d", pct, want.pct));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [W_CONTACT-1:0] i_electrode_contact;
    logic                 i_force_req;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_publish;
    logic [W_PCT-1:0]     o_level_percent;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [W_CFG_IDX-1:0] i_cfg_index;
    logic [W_PCT-1:0]     i_cfg_data;

    t_publish_board board;
    bit             calm;        // last phase: no stalls on either side
    bit             hold_req;    // asks the receiver for one long hold-off
    int unsigned    pause_odds;  // sender gap rate, 0 = none

    electrode_level_mode_filter dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_electrode_contact (i_electrode_contact),
        .i_force_req         (i_force_req),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_publish           (o_publish),
        .o_level_percent     (o_level_percent),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // All handshakes are observed at the rising edge; inputs only move at the falling
    // edge, so pre-edge values are what the block saw.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            board.note_sample(i_electrode_contact, i_force_req);
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_publish(o_publish, o_level_percent);
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            board.load_reg(i_cfg_index, i_cfg_data);
    end

    // Receiver: stall bursts of random length at a rate that changes from chunk to chunk
    // (sometimes zero), plus the one long hold-off, counted here.
    initial begin : out_ready_driver
        int unsigned chunk_left;
        int unsigned stall_odds;
        i_out_ready = 1'b0;
        chunk_left  = 0;
        stall_odds  = 0;
        forever begin
            @(negedge i_clk);
            if (chunk_left == 0) begin
                chunk_left = 100;
                stall_odds = $urandom_range(0, 2);
            end
            chunk_left--;
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && stall_odds != 0
                         && $urandom_range(0, 12 / stall_odds) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // Offer one word and hold it until taken; returns on the following falling edge
    // with valid still high, so a back-to-back word needs no extra edge.
    task automatic send_word(input logic [W_CONTACT-1:0] contact, input logic forced);
        i_in_valid          = 1'b1;
        i_electrode_contact = contact;
        i_force_req         = forced;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Sender gap; payload wanders while valid is low
    task automatic maybe_pause();
        int unsigned n;
        if (!calm && pause_odds != 0 && $urandom_range(0, 15 / pause_odds) == 0) begin
            n = $urandom_range(1, 19);
            i_in_valid          = 1'b0;
            i_electrode_contact = W_CONTACT'($urandom_range(0, 3));
            i_force_req         = 1'($urandom_range(0, 1));
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Stop sending and wait until every owed result word has come out
    task automatic settle(input int unsigned tail);
        i_in_valid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (tail) @(negedge i_clk);
    endtask

    // Leaves cfg valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [W_CFG_IDX-1:0] idx, input logic [W_PCT-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [W_PCT-1:0] lo, input logic [W_PCT-1:0] hi,
                             input logic [W_PCT-1:0] th, input bit poke_spare);
        write_reg(REG_PCT_LOW, lo);
        write_reg(REG_PCT_HIGH, hi);
        write_reg(REG_THRESH, th);
        if (poke_spare) write_reg(REG_SPARE, 7'h7F);
        i_cfg_valid = 1'b0;
    endtask

    // Mostly in range, sometimes above 100 to hit the clamp
    function automatic logic [W_PCT-1:0] pick_pct();
        if ($urandom_range(0, 7) == 0) return W_PCT'($urandom_range(101, 127));
        return W_PCT'($urandom_range(0, 100));
    endfunction

    // Mostly small deadbands so the mode keeps publishing
    function automatic logic [W_PCT-1:0] pick_threshold();
        if ($urandom_range(0, 5) == 0) return W_PCT'($urandom_range(0, 127));
        return W_PCT'($urandom_range(0, 20));
    endfunction

    // Tank-like levels: runs of one contact pattern with some noise and rare forces
    task automatic sample_levels(input int unsigned count);
        int unsigned          run_left;
        logic [W_CONTACT-1:0] steady;
        logic [W_CONTACT-1:0] contact;
        run_left = 0;
        steady   = '0;
        for (int unsigned k = 0; k < count; k++) begin
            if (k % 40 == 0) pause_odds = $urandom_range(0, 3);
            if (run_left == 0) begin
                steady   = W_CONTACT'($urandom_range(0, 3));
                run_left = $urandom_range(1, 12);
            end
            run_left--;
            contact = ($urandom_range(0, 5) == 0) ? W_CONTACT'($urandom_range(0, 3)) : steady;
            send_word(contact, $urandom_range(0, 19) == 0);
            maybe_pause();
        end
    endtask

    initial begin : stimulus
        logic [3:0] nib;
        board               = new();
        calm                = 1'b0;
        hold_req            = 1'b0;
        pause_odds          = 1;
        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_electrode_contact = '0;
        i_force_req         = 1'b0;
        i_cfg_valid         = 1'b0;
        i_cfg_index         = '0;
        i_cfg_data          = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, reset config
        for (int k = 0; k < N_DIRECTED; k++) begin
            nib = DIRECTED_SEQ[4*(N_DIRECTED-1-k) +: 4];
            send_word(nib[1:0], nib[3]);
            maybe_pause();
        end

        // Config only changes with the pipeline empty. Fixed phases cover zero
        // threshold, threshold above 100, clamping in both registers and the spare
        // index; the rest are random.
        for (int ph = 1; ph <= PHASES; ph++) begin
            settle(4);
            case (ph)
                1:       configure(7'd0, 7'd127, 7'd0, 1'b1);
                2:       configure(7'd127, 7'd0, 7'd127, 1'b0);
                3:       configure(7'd100, 7'd101, 7'd100, 1'b0);
                4:       configure(7'd42, 7'd85, 7'd1, 1'b0);
                default: configure(pick_pct(), pick_pct(), pick_threshold(), 1'b0);
            endcase
            calm = (ph == PHASES);
            if (ph == 3) hold_req = 1'b1;  // sender keeps offering through it
            sample_levels(PHASE_WORDS);
        end

        settle(10);
        if (board.pending() != 0)
            board.report($sformatf("%0d result words never came", board.pending()));
        if (board.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
